>>> src/ksazd_pkg.sv
package ksazd_pkg;

  localparam int unsigned NumClickSlots = 7;
  localparam int unsigned NumHoldSlots  = 4;  // 0..2 shared offset/trigger, 3 time offset
  localparam int unsigned ClickIdxW     = 3;
  localparam int unsigned HoldIdxW      = 2;

  // Click interval thresholds in ms
  localparam logic [31:0] SlowMs = 32'd75;
  localparam logic [31:0] MidMs  = 32'd50;
  localparam logic [31:0] FastMs = 32'd25;

  localparam logic [9:0]  StepSizeRst = 10'd1;
  localparam logic [15:0] HoldMsRst   = 16'd500;

  localparam logic [HoldIdxW-1:0]  TimeHoldSlot  = 2'd3;
  localparam logic [ClickIdxW-1:0] TimeClickSlot = 3'd6;

  typedef enum logic [1:0] {
    CMD_VERT_A  = 2'd0,
    CMD_VERT_B  = 2'd1,
    CMD_TRIG    = 2'd2,
    CMD_TIME    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_STEP_SIZE     = 2'd0,
    REG_VERTICAL_ZERO = 2'd1,
    REG_TRIGGER_ZERO  = 2'd2,
    REG_HOLD_MS       = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]         command;
    logic               direction;
    logic [1:0]         hold_src;
    logic [31:0]        now_ms;
    logic signed [15:0] current_value;
  } ksazd_in_t;

  typedef struct packed {
    logic signed [15:0] new_value;
    logic               apply;
    logic [2:0]         multiplier;
  } ksazd_out_t;

endpackage

>>> src/knob_step_accelerator_with_zero_detent.sv
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------
// in       | in  | in_valid_i / in_stall_o   | in_item_i  (ksazd_in_t)
// out      | out | out_valid_o / out_stall_i | out_item_o (ksazd_out_t)
// cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One item per cycle while out_stall_i is low; each item is registered on accept.
// Items land in an input register, the whole step runs in one combinational
// pass to the result register, and click/hold state updates on that same edge.
// Reset (rst_ni low, async) clears all timers, hold flags and valid bits.
// A stalled result holds the result register; the input register keeps
// accepting until it is also occupied, then in_stall_o rises.
module knob_step_accelerator_with_zero_detent (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ksazd_pkg::ksazd_in_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ksazd_pkg::ksazd_out_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);
  import ksazd_pkg::*;

  // Configuration
  logic [9:0]         step_size_q;
  logic signed [15:0] vert_zero_q;
  logic signed [15:0] trig_zero_q;
  logic [15:0]        hold_ms_q;

  // Pipeline
  logic       in_valid_q;
  ksazd_in_t  in_q;
  logic       out_valid_q;
  ksazd_out_t out_q;
  logic       fire;

  // Knob state
  logic [31:0] last_click_q [NumClickSlots];
  logic [31:0] hold_start_q [NumHoldSlots];
  logic [NumHoldSlots-1:0] hold_act_q;

  // Step datapath
  logic [ClickIdxW-1:0] click_slot;
  logic [31:0]          delta;
  logic [2:0]           mult;
  logic [12:0]          step;
  logic signed [15:0]   zero;
  logic signed [17:0]   cur_x, zero_x, sum, snapped;
  logic signed [15:0]   new_val;
  logic                 at_zero;
  logic [HoldIdxW-1:0]  hold_slot;
  logic                 has_slot;
  logic [31:0]          elapsed;
  logic                 expired;
  logic                 apply;

  // Result register frees when empty or being taken
  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= StepSizeRst;
      vert_zero_q <= '0;
      trig_zero_q <= '0;
      hold_ms_q   <= HoldMsRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_STEP_SIZE:     step_size_q <= cfg_data_i[9:0];
        REG_VERTICAL_ZERO: vert_zero_q <= cfg_data_i;
        REG_TRIGGER_ZERO:  trig_zero_q <= cfg_data_i;
        REG_HOLD_MS:       hold_ms_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q.new_value  <= new_val;
      out_q.apply      <= apply;
      out_q.multiplier <= mult;
    end
  end

  // Click timer and hold slot selection
  always_comb begin
    if (cmd_e'(in_q.command) == CMD_TIME) begin
      click_slot = TimeClickSlot;
    end else begin
      click_slot = {in_q.command, in_q.direction};
    end
    case (cmd_e'(in_q.command))
      CMD_VERT_A, CMD_VERT_B: begin
        hold_slot = in_q.command;
        has_slot  = 1'b1;
      end
      CMD_TRIG: begin
        hold_slot = in_q.hold_src;
        has_slot  = (in_q.hold_src != TimeHoldSlot);
      end
      CMD_TIME: begin
        hold_slot = TimeHoldSlot;
        has_slot  = 1'b1;
      end
      default: begin
        hold_slot = TimeHoldSlot;
        has_slot  = 1'b0;
      end
    endcase
  end

  // Acceleration
  always_comb begin
    delta = in_q.now_ms - last_click_q[click_slot];
    if (delta > SlowMs) begin
      mult = 3'd1;
    end else if (delta > MidMs) begin
      mult = 3'd2;
    end else if (delta > FastMs) begin
      mult = 3'd3;
    end else begin
      mult = 3'd4;
    end
  end

  // Step, zero snap, saturation
  always_comb begin
    case (cmd_e'(in_q.command))
      CMD_TIME: begin
        step = {10'd0, mult};
        zero = '0;
      end
      CMD_TRIG: begin
        step = 13'(step_size_q) * 13'(mult);
        zero = trig_zero_q;
      end
      default: begin
        step = 13'(step_size_q) * 13'(mult);
        zero = vert_zero_q;
      end
    endcase
    cur_x  = 18'(in_q.current_value);
    zero_x = 18'(zero);
    if (in_q.direction) begin
      sum = cur_x + $signed({5'd0, step});
    end else begin
      sum = cur_x - $signed({5'd0, step});
    end
    if ((cur_x > zero_x && sum < zero_x) || (cur_x < zero_x && sum > zero_x)) begin
      snapped = zero_x;
    end else begin
      snapped = sum;
    end
    if (snapped > 18'sd32767) begin
      new_val = 16'sh7fff;
    end else if (snapped < -18'sd32768) begin
      new_val = 16'sh8000;
    end else begin
      new_val = snapped[15:0];
    end
    at_zero = (new_val == zero);
  end

  // Detent hold gate
  always_comb begin
    elapsed = in_q.now_ms - hold_start_q[hold_slot];
    expired = (elapsed > {16'd0, hold_ms_q});
    if (!has_slot || at_zero || !hold_act_q[hold_slot]) begin
      apply = 1'b1;
    end else begin
      apply = expired;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClickSlots; i++) begin
        last_click_q[i] <= '0;
      end
      for (int i = 0; i < NumHoldSlots; i++) begin
        hold_start_q[i] <= '0;
      end
      hold_act_q <= '0;
    end else if (fire) begin
      last_click_q[click_slot] <= in_q.now_ms;
      if (has_slot) begin
        if (at_zero) begin
          hold_start_q[hold_slot] <= in_q.now_ms;
          hold_act_q[hold_slot]   <= 1'b1;
        end else if (hold_act_q[hold_slot] && expired) begin
          hold_act_q[hold_slot] <= 1'b0;
        end
      end
    end
  end

  // Landing on the detent is always applied
  a_zero_applies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && at_zero |=> out_q.apply)
    else $error("detent landing not applied");

  // A held knob must have an active hold slot
  a_held_has_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !apply |-> has_slot && hold_act_q[hold_slot])
    else $error("refusal without active hold");

  // Detent landing arms the hold
  a_zero_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && at_zero && has_slot |=> hold_act_q[$past(hold_slot)])
    else $error("hold not armed");

  // Input stage keeps a waiting item intact
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("input stage lost item");

  // Multiplier stays in range
  a_mult_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.multiplier >= 3'd1 && out_q.multiplier <= 3'd4)
    else $error("multiplier out of range");

endmodule
